>>> hdl/crdh_pkg.sv
// Shared types and constants for the count-rate delta history ring.
// Used by every module of the block; depends on nothing.
package crdh_pkg;

  localparam int unsigned RING_DEPTH_DEF = 16384;
  localparam int unsigned MAX_RETURN_DEF = 64;
  localparam int unsigned MAXI_W         = 7;
  localparam int unsigned DUR_W          = 16;
  localparam int unsigned EPOCH_W        = 30;
  localparam int unsigned STAT_W         = 3;
  localparam int unsigned ALU_W          = 33;

  typedef enum logic [STAT_W-1:0] {
    ST_BASELINE = 3'd0,
    ST_STORED   = 3'd1,
    ST_ROLLBACK = 3'd2,
    ST_NO_STEP  = 3'd3,
    ST_RESYNC   = 3'd4,
    ST_QUERY    = 3'd5
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0]      end_time;
    logic [31:0]      delta_counts;
    logic [DUR_W-1:0] duration;
  } ring_entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CNT,
    S_SEC,
    S_RB,
    S_SEQ,
    S_NEXT,
    S_EPOCH,
    Q_FROM,
    Q_OLD1,
    Q_OLD2,
    Q_CLAMP,
    Q_RANGE,
    Q_AVAIL,
    Q_LIMIT,
    Q_IDX,
    Q_WRAP,
    S_READ,
    S_LOAD,
    S_OUT
  } state_e;

endpackage

>>> hdl/crdh_alu.sv
// Shared 33-bit add/subtract unit with carry or borrow flag.
// Depends on crdh_pkg for the request type.
module crdh_alu (
  input  crdh_pkg::alu_req_t               req_i,
  output logic [crdh_pkg::ALU_W-1:0]       res_o,
  output logic                             flag_o
);
  import crdh_pkg::*;

  // On a subtract the flag is the borrow, so it reads as a < b.
  always_comb begin
    if (req_i.op == ALU_SUB) begin
      {flag_o, res_o} = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      {flag_o, res_o} = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
  end

endmodule

>>> hdl/crdh_ring.sv
// Sample storage for the history ring: one write port, one registered read port.
// Depends on crdh_pkg for the entry type.
module crdh_ring #(
  parameter int unsigned DEPTH = crdh_pkg::RING_DEPTH_DEF,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IDX_W-1:0]      waddr_i,
  input  crdh_pkg::ring_entry_t wdata_i,
  input  logic                  re_i,
  input  logic [IDX_W-1:0]      raddr_i,
  output crdh_pkg::ring_entry_t rdata_o
);
  import crdh_pkg::*;

  ring_entry_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> hdl/count_rate_delta_history_ring_unit.sv
// Top level of the count-rate delta history ring: sequencer, state and output word.
// Depends on crdh_pkg, crdh_alu and crdh_ring.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------
//   in      | input     | in_valid_i / in_stall_o  | op, totals, since_seq, max_items
//   out     | output    | out_valid_o / out_stall_i| status .. last, one word per result
//   cfg     | input     | cfg_we_i                 | cfg_wdata_i (epoch_start)
//
// A sample word that only sets the baseline goes through S_NEXT, S_EPOCH and S_OUT; any other
// first runs S_CNT and S_SEC, plus S_RB on a rollback or S_SEQ when it stores, before those.
// A query on a non-empty ring runs Q_FROM on to at most Q_WRAP as needed, then S_NEXT, S_EPOCH
// and, per returned sample, S_READ, S_LOAD and S_OUT, all through the shared adder.
// The input is stalled from acceptance until the last result word has been taken.
// A stalled result word holds; each returned sample costs one ring read.
// Reset clears the control state at once; the ring itself needs no clearing pass.
module count_rate_delta_history_ring_unit #(
  parameter int unsigned RING_DEPTH = crdh_pkg::RING_DEPTH_DEF,
  parameter int unsigned MAX_RETURN = crdh_pkg::MAX_RETURN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [crdh_pkg::EPOCH_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [31:0]                   total_counts_i,
  input  logic [31:0]                   total_seconds_i,
  input  logic [31:0]                   since_seq_i,
  input  logic [crdh_pkg::MAXI_W-1:0]   max_items_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [crdh_pkg::STAT_W-1:0]   status_o,
  output logic                          has_sample_o,
  output logic [31:0]                   sample_seq_o,
  output logic [31:0]                   end_time_o,
  output logic [31:0]                   delta_counts_o,
  output logic [crdh_pkg::DUR_W-1:0]    duration_o,
  output logic [31:0]                   first_seq_o,
  output logic [31:0]                   next_seq_o,
  output logic [31:0]                   epoch_o,
  output logic                          last_o
);
  import crdh_pkg::*;

  localparam int unsigned IDX_W  = $clog2(RING_DEPTH);
  localparam int unsigned HELD_W = $clog2(RING_DEPTH + 1);

  // Control state.
  state_e              state_q, state_d;
  logic [EPOCH_W-1:0]  epoch_start_q;
  logic                base_valid_q;
  logic [IDX_W-1:0]    wr_idx_q;
  logic [HELD_W-1:0]   held_q;
  logic [31:0]         newest_q;
  logic [31:0]         rollback_q;

  // Working and result registers.
  logic                op_q;
  logic [31:0]         cnt_q;
  logic [31:0]         sec_q;
  logic [31:0]         since_q;
  logic [MAXI_W-1:0]   maxi_q;
  logic [31:0]         base_cnt_q;
  logic [31:0]         base_sec_q;
  logic                cnt_borrow_q;
  logic [ALU_W-1:0]    from_q;
  logic [31:0]         tmp_q;
  logic [IDX_W-1:0]    rd_idx_q;
  logic [MAXI_W-1:0]   remain_q;
  logic [31:0]         seq_q;

  status_e             status_q;
  logic                has_q;
  logic [31:0]         sseq_q;
  logic [31:0]         end_q;
  logic [31:0]         dc_q;
  logic [DUR_W-1:0]    dur_q;
  logic [31:0]         first_q;
  logic [31:0]         next_q;
  logic [31:0]         epoch_q;
  logic                last_q;

  alu_req_t            alu_req;
  logic [ALU_W-1:0]    alu_res;
  logic                alu_flag;

  logic                in_acc;
  logic                out_acc;
  logic                rollback;
  logic                step_zero;
  logic                step_jump;
  logic                store_ok;
  logic                ring_we;
  logic                ring_re;
  ring_entry_t         ring_wdata;
  ring_entry_t         ring_rdata;
  logic [MAXI_W-1:0]   maxi_sat;
  logic [MAXI_W-1:0]   n_items;

  crdh_alu u_alu (
    .req_i  (alu_req),
    .res_o  (alu_res),
    .flag_o (alu_flag)
  );

  crdh_ring #(
    .DEPTH (RING_DEPTH),
    .IDX_W (IDX_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (wr_idx_q),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ring_rdata)
  );

  assign in_acc  = in_valid_i && (state_q == S_IDLE);
  assign out_acc = (state_q == S_OUT) && !out_stall_i;

  // Decisions taken in the cycle that subtracts the seconds baseline.
  assign rollback  = cnt_borrow_q || alu_flag;
  assign step_zero = (alu_res[31:0] == 32'd0);
  assign step_jump = (alu_res[31:DUR_W] != '0);
  assign store_ok  = !rollback && !step_zero && !step_jump;

  assign maxi_sat = (max_items_i > MAXI_W'(MAX_RETURN)) ? MAXI_W'(MAX_RETURN) : max_items_i;
  // Fewer samples available than asked for: the count fits the item width.
  assign n_items  = alu_flag ? tmp_q[MAXI_W-1:0] : maxi_q;

  assign ring_wdata.end_time     = sec_q;
  assign ring_wdata.delta_counts = dc_q;
  assign ring_wdata.duration     = alu_res[DUR_W-1:0];

  // Shared unit operand selection and port-side controls.
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    ring_we    = 1'b0;
    ring_re    = 1'b0;
    case (state_q)
      S_CNT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {1'b0, cnt_q};
        alu_req.b  = {1'b0, base_cnt_q};
      end
      S_SEC: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {1'b0, sec_q};
        alu_req.b  = {1'b0, base_sec_q};
        ring_we    = store_ok;
      end
      S_RB: begin
        alu_req.a = {1'b0, rollback_q};
        alu_req.b = ALU_W'(1);
      end
      S_SEQ, S_NEXT: begin
        alu_req.a = {1'b0, newest_q};
        alu_req.b = ALU_W'(1);
      end
      S_EPOCH: begin
        alu_req.a = ALU_W'(epoch_start_q);
        alu_req.b = {1'b0, rollback_q};
      end
      Q_FROM: begin
        alu_req.a = {1'b0, since_q};
        alu_req.b = ALU_W'(1);
      end
      Q_OLD1: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {1'b0, newest_q};
        alu_req.b  = ALU_W'(held_q);
      end
      Q_OLD2, Q_AVAIL: begin
        alu_req.a = {1'b0, tmp_q};
        alu_req.b = ALU_W'(1);
      end
      Q_CLAMP: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = from_q;
        alu_req.b  = {1'b0, tmp_q};
      end
      Q_RANGE: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {1'b0, newest_q};
        alu_req.b  = from_q;
      end
      Q_LIMIT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {1'b0, tmp_q};
        alu_req.b  = ALU_W'(maxi_q);
      end
      Q_IDX: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(wr_idx_q);
        alu_req.b  = {1'b0, tmp_q};
      end
      Q_WRAP: begin
        alu_req.a = {1'b0, tmp_q};
        alu_req.b = ALU_W'(RING_DEPTH);
      end
      S_READ: begin
        ring_re = 1'b1;
      end
      S_LOAD: begin
        alu_req.a = {1'b0, seq_q};
        alu_req.b = ALU_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (op_i) begin
            state_d = (held_q == '0) ? S_NEXT : Q_FROM;
          end else begin
            state_d = base_valid_q ? S_CNT : S_NEXT;
          end
        end
      end
      S_CNT:   state_d = S_SEC;
      S_SEC: begin
        if (rollback) begin
          state_d = S_RB;
        end else if (store_ok) begin
          state_d = S_SEQ;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_RB:    state_d = S_NEXT;
      S_SEQ:   state_d = S_NEXT;
      S_NEXT:  state_d = S_EPOCH;
      S_EPOCH: state_d = has_q ? S_READ : S_OUT;
      Q_FROM:  state_d = Q_OLD1;
      Q_OLD1:  state_d = Q_OLD2;
      Q_OLD2:  state_d = Q_CLAMP;
      Q_CLAMP: state_d = Q_RANGE;
      Q_RANGE: state_d = alu_flag ? S_NEXT : Q_AVAIL;
      Q_AVAIL: state_d = Q_LIMIT;
      Q_LIMIT: state_d = (maxi_q == '0) ? S_NEXT : Q_IDX;
      Q_IDX:   state_d = alu_flag ? Q_WRAP : S_NEXT;
      Q_WRAP:  state_d = S_NEXT;
      S_READ:  state_d = S_LOAD;
      S_LOAD:  state_d = S_OUT;
      S_OUT: begin
        if (out_acc) begin
          state_d = last_q ? S_IDLE : S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      epoch_start_q <= '0;
      base_valid_q  <= 1'b0;
      wr_idx_q      <= '0;
      held_q        <= '0;
      newest_q      <= '0;
      rollback_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        epoch_start_q <= cfg_wdata_i;
      end
      if (in_acc && !op_i) begin
        base_valid_q <= 1'b1;
      end
      if (state_q == S_SEC) begin
        if (rollback) begin
          wr_idx_q <= '0;
          held_q   <= '0;
        end else if (store_ok) begin
          wr_idx_q <= (wr_idx_q == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
          if (held_q != HELD_W'(RING_DEPTH)) begin
            held_q <= held_q + 1'b1;
          end
        end
      end
      if (state_q == S_RB) begin
        rollback_q <= alu_res[31:0];
      end
      if (state_q == S_SEQ) begin
        newest_q <= alu_res[31:0];
      end
    end
  end

  // Datapath and result word; no reset needed.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_q     <= op_i;
          cnt_q    <= total_counts_i;
          sec_q    <= total_seconds_i;
          since_q  <= since_seq_i;
          maxi_q   <= maxi_sat;
          has_q    <= 1'b0;
          last_q   <= 1'b1;
          sseq_q   <= '0;
          end_q    <= '0;
          dc_q     <= '0;
          dur_q    <= '0;
          if (op_i) begin
            status_q <= ST_QUERY;
          end else begin
            status_q <= ST_BASELINE;
            if (!base_valid_q) begin
              base_cnt_q <= total_counts_i;
              base_sec_q <= total_seconds_i;
            end
          end
        end
      end
      S_CNT: begin
        cnt_borrow_q <= alu_flag;
        dc_q         <= alu_res[31:0];
      end
      S_SEC: begin
        if (rollback) begin
          status_q   <= ST_ROLLBACK;
          base_cnt_q <= cnt_q;
          base_sec_q <= sec_q;
          dc_q       <= '0;
        end else if (step_zero) begin
          status_q <= ST_NO_STEP;
          dc_q     <= '0;
        end else if (step_jump) begin
          status_q   <= ST_RESYNC;
          base_cnt_q <= cnt_q;
          base_sec_q <= sec_q;
          dc_q       <= '0;
        end else begin
          status_q   <= ST_STORED;
          base_cnt_q <= cnt_q;
          base_sec_q <= sec_q;
          end_q      <= sec_q;
          dur_q      <= alu_res[DUR_W-1:0];
        end
      end
      S_SEQ: begin
        sseq_q <= alu_res[31:0];
      end
      S_NEXT: begin
        next_q <= alu_res[31:0];
        if (!has_q) begin
          first_q <= alu_res[31:0];
        end
      end
      S_EPOCH: begin
        epoch_q <= alu_res[31:0];
      end
      Q_FROM: begin
        from_q <= alu_res;
      end
      Q_OLD1, Q_OLD2, Q_AVAIL: begin
        tmp_q <= alu_res[31:0];
      end
      Q_CLAMP: begin
        // Raise the start to the oldest sample still held.
        if (alu_flag) begin
          from_q <= {1'b0, tmp_q};
        end
      end
      Q_RANGE: begin
        tmp_q <= alu_res[31:0];
      end
      Q_LIMIT: begin
        if (maxi_q != '0) begin
          has_q    <= 1'b1;
          remain_q <= n_items;
          first_q  <= from_q[31:0];
          seq_q    <= from_q[31:0];
        end
      end
      Q_IDX: begin
        // The first sample sits tmp_q entries behind the write pointer.
        tmp_q    <= alu_res[31:0];
        rd_idx_q <= alu_res[IDX_W-1:0];
      end
      Q_WRAP: begin
        rd_idx_q <= alu_res[IDX_W-1:0];
      end
      S_READ: begin
        rd_idx_q <= (rd_idx_q == IDX_W'(RING_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
        remain_q <= remain_q - 1'b1;
      end
      S_LOAD: begin
        sseq_q <= seq_q;
        end_q  <= ring_rdata.end_time;
        dc_q   <= ring_rdata.delta_counts;
        dur_q  <= ring_rdata.duration;
        last_q <= (remain_q == '0);
        seq_q  <= alu_res[31:0];
      end
      default: begin
      end
    endcase
  end

  // op_q records the kind of word in flight; a sample never returns stored entries.
  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = (state_q == S_OUT);
  assign status_o       = status_q;
  assign has_sample_o   = has_q && op_q;
  assign sample_seq_o   = sseq_q;
  assign end_time_o     = end_q;
  assign delta_counts_o = dc_q;
  assign duration_o     = dur_q;
  assign first_seq_o    = first_q;
  assign next_seq_o     = next_q;
  assign epoch_o        = epoch_q;
  assign last_o         = last_q;

endmodule

>>> hdl/crdh_checker.sv
// Port-level checks for the count-rate delta history ring, bound to the top level.
// Depends on crdh_pkg and count_rate_delta_history_ring_unit.
module crdh_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [crdh_pkg::STAT_W-1:0] status_o,
  input logic                        has_sample_o,
  input logic [31:0]                 first_seq_o,
  input logic [31:0]                 next_seq_o,
  input logic                        last_o
);
  import crdh_pkg::*;

  // An accepted word keeps the input stalled while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a word was accepted");

  // No new word is taken while a result is pending.
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result is pending");

  // Only a query can produce more than one result.
  a_multi_only_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == ST_QUERY && has_sample_o)
    else $error("non-final result that is not a query sample");

  // Results without a sample report first_seq equal to next_seq.
  a_first_eq_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_sample_o |-> first_seq_o == next_seq_o)
    else $error("first_seq differs from next_seq on an empty result");

  // After a non-final query result is taken, the next one needs a fresh ring read.
  a_gap_between_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> !out_valid_o)
    else $error("query results issued without a ring read between them");

endmodule

bind count_rate_delta_history_ring_unit crdh_checker u_crdh_checker (.*);

>>> tb/tb_count_rate_delta_history_ring_unit.sv
// Self-checking testbench for count_rate_delta_history_ring_unit.
// A scoreboard class predicts every result word from the accepted words; it depends
// only on crdh_pkg and the unit itself.
module tb_count_rate_delta_history_ring_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import crdh_pkg::*;

  localparam int unsigned RING          = RING_DEPTH_DEF;
  localparam int unsigned MAX_RET       = MAX_RETURN_DEF;
  localparam bit [31:0]   DUR_MAX       = (32'd1 << DUR_W) - 32'd1;
  localparam bit [EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam bit          OP_SAMPLE     = 1'b0;
  localparam bit          OP_QUERY      = 1'b1;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned DRAIN_LIMIT   = 100000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS   = 97;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic              has_sample;
    logic [31:0]       sample_seq;
    logic [31:0]       end_time;
    logic [31:0]       delta_counts;
    logic [DUR_W-1:0]  duration;
    logic [31:0]       first_seq;
    logic [31:0]       next_seq;
    logic [31:0]       epoch;
    logic              last;
  } hist_word_t;

  class ring_scoreboard;
    bit               base_ok;
    bit [31:0]        base_counts;
    bit [31:0]        base_secs;
    bit [31:0]        newest;
    bit [31:0]        rollbacks;
    bit [EPOCH_W-1:0] epoch_start;
    int unsigned      wr_idx;
    int unsigned      held;
    bit [31:0]        mem_end [RING];
    bit [31:0]        mem_dc [RING];
    bit [DUR_W-1:0]   mem_dur [RING];
    hist_word_t       expected_q[$];
    int unsigned      errors;

    task report_mismatch(string msg);
      errors++;
      $display("%0t ns mismatch: %s", $realtime, msg);
    endtask

    function void queue_word(status_e st, bit has, bit [31:0] seq, bit [31:0] end_s,
                             bit [31:0] dc, bit [DUR_W-1:0] dur, bit [31:0] first, bit last);
      hist_word_t w;
      w.status       = st;
      w.has_sample   = has;
      w.sample_seq   = seq;
      w.end_time     = end_s;
      w.delta_counts = dc;
      w.duration     = dur;
      w.first_seq    = first;
      w.next_seq     = newest + 32'd1;
      w.epoch        = {{(32 - EPOCH_W){1'b0}}, epoch_start} + rollbacks;
      w.last         = last;
      expected_q.push_back(w);
    endfunction

    function void note_sample(bit [31:0] cnt, bit [31:0] sec);
      bit [31:0]      dsec;
      bit [31:0]      seq;
      bit [31:0]      end_s;
      bit [31:0]      dc;
      bit [DUR_W-1:0] dur;
      status_e        st;
      seq   = '0;
      end_s = '0;
      dc    = '0;
      dur   = '0;
      dsec  = sec - base_secs;
      if (!base_ok) begin
        base_ok     = 1'b1;
        base_counts = cnt;
        base_secs   = sec;
        st          = ST_BASELINE;
      end else if (cnt < base_counts || sec < base_secs) begin
        // A counter reset on the instrument side starts a new epoch; sequence numbers go on.
        rollbacks++;
        held        = 0;
        wr_idx      = 0;
        base_counts = cnt;
        base_secs   = sec;
        st          = ST_ROLLBACK;
      end else if (dsec == 0) begin
        st = ST_NO_STEP;
      end else if (dsec > DUR_MAX) begin
        base_counts = cnt;
        base_secs   = sec;
        st          = ST_RESYNC;
      end else begin
        dc    = cnt - base_counts;
        end_s = sec;
        dur   = dsec[DUR_W-1:0];
        mem_end[wr_idx] = end_s;
        mem_dc[wr_idx]  = dc;
        mem_dur[wr_idx] = dur;
        wr_idx = (wr_idx + 1) % RING;
        if (held < RING) held++;
        newest++;
        seq         = newest;
        base_counts = cnt;
        base_secs   = sec;
        st          = ST_STORED;
      end
      queue_word(st, 1'b0, seq, end_s, dc, dur, newest + 32'd1, 1'b1);
    endfunction

    function void note_query(bit [31:0] since, bit [MAXI_W-1:0] maxi);
      bit [31:0]   next_s;
      bit [31:0]   first;
      bit [31:0]   oldest;
      bit [32:0]   start_seq;
      bit [31:0]   seq;
      int unsigned lim;
      int unsigned n;
      int unsigned avail;
      int unsigned back;
      int unsigned idx;
      next_s = newest + 32'd1;
      first  = next_s;
      n      = 0;
      lim    = (maxi > MAX_RET) ? MAX_RET : maxi;
      if (held > 0) begin
        oldest    = newest - held + 32'd1;
        // since_seq + 1 does not wrap, so a query past the top finds nothing.
        start_seq = {1'b0, since} + 33'd1;
        if (start_seq < {1'b0, oldest}) start_seq = {1'b0, oldest};
        if (start_seq <= {1'b0, newest}) begin
          avail = newest - start_seq[31:0] + 32'd1;
          n     = (avail > lim) ? lim : avail;
          if (n > 0) first = start_seq[31:0];
        end
      end
      if (n == 0) begin
        queue_word(ST_QUERY, 1'b0, '0, '0, '0, '0, next_s, 1'b1);
        return;
      end
      for (int unsigned i = 0; i < n; i++) begin
        seq  = first + i;
        back = newest - seq + 32'd1;
        idx  = (wr_idx + RING - back) % RING;
        queue_word(ST_QUERY, 1'b1, seq, mem_end[idx], mem_dc[idx], mem_dur[idx], first,
                   i + 1 == n);
      end
    endfunction

    function void note_input(bit op, bit [31:0] cnt, bit [31:0] sec, bit [31:0] since,
                             bit [MAXI_W-1:0] maxi);
      if (op == OP_SAMPLE) note_sample(cnt, sec);
      else note_query(since, maxi);
    endfunction

    task compare_field(string name, logic [31:0] got, logic [31:0] want,
                       logic [31:0] seq);
      if (got !== want)
        report_mismatch($sformatf("%s got %h expected %h (sample_seq %0d)", name, got, want,
                                  seq));
    endtask

    task check_result(hist_word_t got);
      hist_word_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result word arrived with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", got.status, want.status, want.sample_seq);
      compare_field("has_sample", got.has_sample, want.has_sample, want.sample_seq);
      compare_field("sample_seq", got.sample_seq, want.sample_seq, want.sample_seq);
      compare_field("end_time", got.end_time, want.end_time, want.sample_seq);
      compare_field("delta_counts", got.delta_counts, want.delta_counts, want.sample_seq);
      compare_field("duration", got.duration, want.duration, want.sample_seq);
      compare_field("first_seq", got.first_seq, want.first_seq, want.sample_seq);
      compare_field("next_seq", got.next_seq, want.next_seq, want.sample_seq);
      compare_field("epoch", got.epoch, want.epoch, want.sample_seq);
      compare_field("last", got.last, want.last, want.sample_seq);
    endtask
  endclass

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [EPOCH_W-1:0] cfg_wdata_i     = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic               op_i            = 1'b0;
  logic [31:0]        total_counts_i  = '0;
  logic [31:0]        total_seconds_i = '0;
  logic [31:0]        since_seq_i     = '0;
  logic [MAXI_W-1:0]  max_items_i     = '0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [STAT_W-1:0]  status_o;
  logic               has_sample_o;
  logic [31:0]        sample_seq_o;
  logic [31:0]        end_time_o;
  logic [31:0]        delta_counts_o;
  logic [DUR_W-1:0]   duration_o;
  logic [31:0]        first_seq_o;
  logic [31:0]        next_seq_o;
  logic [31:0]        epoch_o;
  logic               last_o;

  ring_scoreboard sb;
  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct     = 0;
  bit             hold_go       = 1'b0;
  bit             hold_on       = 1'b0;

  count_rate_delta_history_ring_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .total_counts_i  (total_counts_i),
    .total_seconds_i (total_seconds_i),
    .since_seq_i     (since_seq_i),
    .max_items_i     (max_items_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .has_sample_o    (has_sample_o),
    .sample_seq_o    (sample_seq_o),
    .end_time_o      (end_time_o),
    .delta_counts_o  (delta_counts_o),
    .duration_o      (duration_o),
    .first_seq_o     (first_seq_o),
    .next_seq_o      (next_seq_o),
    .epoch_o         (epoch_o),
    .last_o          (last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= hold_on || ($urandom_range(99) < stall_pct);
  end

  // Long receiver hold-off: the unit takes one word, then has to stall its input.
  initial begin : receiver_hold
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin : result_watch
    hist_word_t got;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got.status       = status_o;
      got.has_sample   = has_sample_o;
      got.sample_seq   = sample_seq_o;
      got.end_time     = end_time_o;
      got.delta_counts = delta_counts_o;
      got.duration     = duration_o;
      got.first_seq    = first_seq_o;
      got.next_seq     = next_seq_o;
      got.epoch        = epoch_o;
      got.last         = last_o;
      sb.check_result(got);
    end
  end

  // Called at a rising edge; returns at the edge where the word was taken.
  task automatic send_word(input bit op, input bit [31:0] cnt, input bit [31:0] sec,
                           input bit [31:0] since, input bit [MAXI_W-1:0] maxi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    total_counts_i  <= cnt;
    total_seconds_i <= sec;
    since_seq_i     <= since;
    max_items_i     <= maxi;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_input(op, cnt, sec, since, maxi);
  endtask

  task automatic write_epoch_start(input bit [EPOCH_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.epoch_start = value;
  endtask

  task automatic drain();
    int unsigned n;
    in_valid_i <= 1'b0;
    n = 0;
    while (sb.expected_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    if (sb.expected_q.size() != 0) begin
      sb.report_mismatch($sformatf("%0d expected result words never arrived",
                                   sb.expected_q.size()));
      sb.expected_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_item();
    bit [31:0]         cnt;
    bit [31:0]         sec;
    bit [31:0]         since;
    bit [MAXI_W-1:0]   maxi;
    int unsigned       pick;
    cnt   = $urandom;
    sec   = $urandom;
    since = $urandom;
    maxi  = MAXI_W'($urandom);
    pick  = $urandom_range(99);
    if (pick < 25) begin
      if ($urandom_range(3) != 0) maxi = MAXI_W'($urandom_range(8));
      case ($urandom_range(3))
        0: since = sb.newest - 32'($urandom_range(20));
        1: since = sb.newest - sb.held + 32'($urandom_range(3)) - 32'd2;
        2: since = '0;
        default: ;
      endcase
      send_word(OP_QUERY, cnt, sec, since, maxi);
    end else begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        sec = sb.base_secs + (($urandom_range(9) == 0) ? $urandom_range(1, DUR_MAX)
                                                         : $urandom_range(1, 300));
        cnt = sb.base_counts + (($urandom_range(9) == 0) ? $urandom_range(0, 32'h00FF_FFFF)
                                                           : $urandom_range(0, 5000));
      end else if (pick < 80) begin
        sec = sb.base_secs;
        cnt = sb.base_counts + $urandom_range(0, 100);
      end else if (pick < 87) begin
        sec = sb.base_secs + $urandom_range(DUR_MAX + 1, 32'h0010_0000);
        cnt = sb.base_counts + $urandom_range(0, 5000);
      end else if (pick < 94) begin
        if ($urandom_range(1) == 0) begin
          cnt = sb.base_counts - $urandom_range(1, 1000);
          sec = sb.base_secs + $urandom_range(0, 10);
        end else begin
          cnt = sb.base_counts + $urandom_range(0, 1000);
          sec = sb.base_secs - $urandom_range(1, 1000);
        end
      end
      send_word(OP_SAMPLE, cnt, sec, since, maxi);
    end
  endtask

  initial begin
    #20ms;
    $display("tb_count_rate_delta_history_ring_unit failed");
    $finish;
  end

  initial begin : main_flow
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_epoch_start(EPOCH_MAX);
    // Query before any baseline, then baseline, no time step, extreme counts and durations.
    send_word(OP_QUERY, 32'd0, 32'd0, 32'd0, 7'd5);
    send_word(OP_SAMPLE, 32'd0, 32'd0, 32'd0, 7'd0);
    send_word(OP_SAMPLE, 32'd0, 32'd0, 32'd0, 7'd0);
    send_word(OP_SAMPLE, 32'hFFFF_FFFF, 32'd1, 32'd0, 7'd0);
    send_word(OP_SAMPLE, 32'hFFFF_FFFF, 32'd65536, 32'd0, 7'd0);
    send_word(OP_SAMPLE, 32'hFFFF_FFFF, 32'd131072, 32'd0, 7'd0);
    send_word(OP_SAMPLE, 32'hFFFF_FFFF, 32'd131080, 32'd0, 7'd0);
    send_word(OP_QUERY, 32'd0, 32'd0, 32'd0, 7'h7F);
    send_word(OP_QUERY, 32'd0, 32'd0, 32'd0, 7'd0);
    send_word(OP_QUERY, 32'd0, 32'd0, 32'd2, 7'd1);
    send_word(OP_QUERY, 32'd0, 32'd0, 32'd3, 7'd64);
    send_word(OP_QUERY, 32'd0, 32'd0, 32'hFFFF_FFFF, 7'd64);
    // Counts fall: new epoch with an empty ring.
    send_word(OP_SAMPLE, 32'd5, 32'd200000, 32'd0, 7'd0);
    send_word(OP_QUERY, 32'd0, 32'd0, 32'd0, 7'd64);
    send_word(OP_SAMPLE, 32'd10, 32'd200010, 32'd0, 7'd0);
    // Seconds fall, then a jump to the top of the range and a repeat of it.
    send_word(OP_SAMPLE, 32'd10, 32'd100, 32'd0, 7'd0);
    send_word(OP_SAMPLE, 32'd20, 32'hFFFF_FFFF, 32'd0, 7'd0);
    send_word(OP_SAMPLE, 32'd30, 32'hFFFF_FFFF, 32'd0, 7'd0);
    // Both totals fall; a query from zero is then raised to the oldest held sample.
    send_word(OP_SAMPLE, 32'd0, 32'd0, 32'd0, 7'd0);
    send_word(OP_SAMPLE, 32'd1, 32'd1, 32'd0, 7'd0);
    send_word(OP_SAMPLE, 32'd2, 32'd2, 32'd0, 7'd0);
    send_word(OP_QUERY, 32'd0, 32'd0, 32'd0, 7'd64);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          write_epoch_start('0);
          hold_go = 1'b1;
        end
        1: begin
          send_idle_pct = 81;
          stall_pct     = 0;
          write_epoch_start(EPOCH_W'($urandom));
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 81;
          write_epoch_start(30'h2AAA_AAAA);
        end
        default: begin
          send_idle_pct = 23;
          stall_pct     = 23;
          write_epoch_start(30'h1555_5555);
        end
      endcase
      repeat (PHASE_ITEMS) random_item();
      drain();
    end

    if (sb.errors == 0) begin
      $display("tb_count_rate_delta_history_ring_unit passed");
    end else begin
      $display("tb_count_rate_delta_history_ring_unit failed");
    end
    $finish;
  end

endmodule
